// File: hw/rtl/hvt_pkg.sv
// Shared types and constants for the homogeneous vertex transform.
// Used by the transform datapath, divider and top level; no dependencies.
package hvt_pkg;

    localparam int CoordW = 16;
    localparam int AccW   = 35;
    localparam int NumW   = AccW + 8;
    localparam int DenW   = AccW - 1;
    localparam int QW     = 26;
    localparam int DivSteps = QW;
    localparam int CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] RegRow0 = 2'd0;
    localparam logic [CfgIdxW-1:0] RegRow1 = 2'd1;
    localparam logic [CfgIdxW-1:0] RegRow2 = 2'd2;
    localparam logic [CfgIdxW-1:0] RegRow3 = 2'd3;

    localparam logic [63:0] Row0Reset = 64'd256;
    localparam logic [63:0] Row1Reset = 64'd16777216;
    localparam logic [63:0] Row2Reset = 64'd1099511627776;
    localparam logic [63:0] Row3Reset = 64'd72057594037927936;

    localparam logic signed [CoordW-1:0] QOne = 16'sd256;

    typedef logic signed [AccW-1:0] acc_t;

    // One coordinate lane flowing through the divider pipeline.
    typedef struct packed {
        logic            neg;
        logic [QW-1:0]   quo;
        logic [NumW-1:0] rem_num;
    } lane_t;

    typedef struct packed {
        logic            w_zero;
        logic [DenW-1:0] den;
    } div_ctl_t;

endpackage

// File: hw/rtl/hvt_dot.sv
// Matrix-vector product: four row dot products over two register stages.
// Depends on hvt_pkg.
module hvt_dot
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic                            in_valid,
    input  logic signed [hvt_pkg::CoordW-1:0] coord_x,
    input  logic signed [hvt_pkg::CoordW-1:0] coord_y,
    input  logic signed [hvt_pkg::CoordW-1:0] coord_z,
    input  logic [63:0]                     rows [4],
    output logic                            out_valid,
    output hvt_pkg::acc_t                   acc [4]
);

    logic signed [31:0] prod_reg [4][4];
    logic signed [31:0] prod_next [4][4];
    logic               p_valid_reg;
    logic               a_valid_reg;
    hvt_pkg::acc_t      acc_reg [4];
    hvt_pkg::acc_t      acc_next [4];
    logic signed [hvt_pkg::CoordW-1:0] vec [4];

    assign vec[0] = coord_x;
    assign vec[1] = coord_y;
    assign vec[2] = coord_z;
    assign vec[3] = hvt_pkg::QOne;

    // Sixteen 16x16 products in parallel; the sums follow in the next stage.
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                prod_next[r][c] = $signed(rows[r][16*c +: 16]) * vec[c];
            end
        end
        for (int r = 0; r < 4; r++)
        begin
            acc_next[r] = hvt_pkg::acc_t'(prod_reg[r][0]) + hvt_pkg::acc_t'(prod_reg[r][1])
                        + hvt_pkg::acc_t'(prod_reg[r][2]) + hvt_pkg::acc_t'(prod_reg[r][3]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            p_valid_reg <= in_valid;
            a_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
        end
    end

    assign out_valid = a_valid_reg;
    assign acc       = acc_reg;

endmodule

// File: hw/rtl/hvt_div.sv
// Pipelined restoring divider for three lanes sharing one divisor,
// one quotient bit per stage, with saturation. Depends on hvt_pkg.
module hvt_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          in_valid,
    input  hvt_pkg::acc_t                 acc [4],
    output logic                          out_valid,
    output logic signed [hvt_pkg::CoordW-1:0] res [3],
    output logic                          w_zero,
    output logic                          saturated
);

    localparam int S = hvt_pkg::DivSteps;

    logic               v_reg [S+1];
    hvt_pkg::div_ctl_t  ctl_reg [S+1];
    hvt_pkg::lane_t     lane_reg [S+1][3];
    hvt_pkg::div_ctl_t  ctl_in;
    hvt_pkg::lane_t     lane_in [3];
    hvt_pkg::lane_t     lane_step [S][3];
    logic               v_out_reg;
    logic signed [hvt_pkg::CoordW-1:0] res_reg [3];
    logic               wz_reg;
    logic               sat_reg;
    logic signed [hvt_pkg::CoordW-1:0] res_next [3];
    logic               sat_next;

    // Entry: magnitudes; numerator scaled by 256 (|acc| < 2^34 so fits NumW).
    always_comb
    begin
        logic [hvt_pkg::AccW-1:0] wmag;
        logic [hvt_pkg::AccW-1:0] nmag;
        wmag = acc[3][hvt_pkg::AccW-1] ? hvt_pkg::AccW'(-acc[3]) : acc[3];
        ctl_in.w_zero = (acc[3] == '0);
        ctl_in.den    = wmag[hvt_pkg::DenW-1:0];
        for (int l = 0; l < 3; l++)
        begin
            nmag = acc[l][hvt_pkg::AccW-1] ? hvt_pkg::AccW'(-acc[l]) : acc[l];
            lane_in[l].neg     = acc[l][hvt_pkg::AccW-1] ^ acc[3][hvt_pkg::AccW-1];
            lane_in[l].quo     = '0;
            lane_in[l].rem_num = {nmag, 8'd0};
        end
    end

    // Step k finds quotient bit QW-1-k. Quotient < 2^42 in general, but bits
    // above QW-1 only matter as "too large"; they are folded in as saturation
    // by the top check on the remaining high numerator bits.
    always_comb
    begin
        for (int k = 0; k < S; k++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                logic [hvt_pkg::NumW+hvt_pkg::QW-1:0] sh;
                lane_step[k][l] = lane_reg[k][l];
                sh = {{(hvt_pkg::NumW+hvt_pkg::QW-hvt_pkg::DenW){1'b0}}, ctl_reg[k].den}
                     << (hvt_pkg::QW - 1 - k);
                if ({{hvt_pkg::QW{1'b0}}, lane_reg[k][l].rem_num} >= sh)
                begin
                    lane_step[k][l].rem_num = hvt_pkg::NumW'({{hvt_pkg::QW{1'b0}},
                                              lane_reg[k][l].rem_num} - sh);
                    lane_step[k][l].quo[hvt_pkg::QW-1-k] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        sat_next = 1'b0;
        for (int l = 0; l < 3; l++)
        begin
            logic [hvt_pkg::NumW+hvt_pkg::QW-1:0] big;
            logic over;
            // Remainder still at least den*2^QW means quotient >= 2^QW.
            big  = {{(hvt_pkg::NumW+hvt_pkg::QW-hvt_pkg::DenW){1'b0}}, ctl_reg[S].den}
                   << hvt_pkg::QW;
            over = ({{hvt_pkg::QW{1'b0}}, lane_reg[S][l].rem_num} >= big)
                 || (lane_reg[S][l].quo >
                     hvt_pkg::QW'(lane_reg[S][l].neg ? 32768 : 32767));
            if (ctl_reg[S].w_zero)
            begin
                res_next[l] = '0;
            end
            else if (over)
            begin
                res_next[l] = lane_reg[S][l].neg ? -16'sd32768 : 16'sd32767;
                sat_next    = 1'b1;
            end
            else
            begin
                res_next[l] = lane_reg[S][l].neg ? -$signed(lane_reg[S][l].quo[15:0])
                                                 : $signed(lane_reg[S][l].quo[15:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= S; k++)
            begin
                v_reg[k] <= 1'b0;
            end
            v_out_reg <= 1'b0;
        end
        else if (advance)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= S; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
            v_out_reg <= v_reg[S];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ctl_reg[0]  <= ctl_in;
            lane_reg[0] <= lane_in;
            for (int k = 1; k <= S; k++)
            begin
                ctl_reg[k]  <= ctl_reg[k-1];
                lane_reg[k] <= lane_step[k-1];
            end
            res_reg <= res_next;
            wz_reg  <= ctl_reg[S].w_zero;
            sat_reg <= sat_next && !ctl_reg[S].w_zero;
        end
    end

    assign out_valid = v_out_reg;
    assign res       = res_reg;
    assign w_zero    = wz_reg;
    assign saturated = sat_reg;

endmodule

// File: hw/rtl/homogeneous_vertex_transform.sv
// Top level of the homogeneous vertex transform.
// Depends on hvt_pkg, hvt_dot and hvt_div.

// Each request carries one signed Q8.8 point; the block extends it with
// w = 1.0, multiplies by the configured 4x4 matrix and divides x, y and z
// by the resulting w, truncating toward zero and saturating to 16 bits.
// A new point can be taken every cycle unless the output stalls. Accepted
// points pass two matrix-product stages, one entry stage and 26 one-bit
// stages of the shared-divisor divider, and then the output register.
// The whole pipeline advances whenever the output register is empty or
// being drained, so a stall on the output holds every stage in place.
// The matrix resets to identity; write rows only while no request is in
// flight.
module homogeneous_vertex_transform
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [hvt_pkg::CoordW-1:0] coord_x,
    input  logic signed [hvt_pkg::CoordW-1:0] coord_y,
    input  logic signed [hvt_pkg::CoordW-1:0] coord_z,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [hvt_pkg::CoordW-1:0] out_x,
    output logic signed [hvt_pkg::CoordW-1:0] out_y,
    output logic signed [hvt_pkg::CoordW-1:0] out_z,
    output logic                            w_zero,
    output logic                            saturated,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hvt_pkg::CfgIdxW:0]       cfg_index,
    input  logic [63:0]                     cfg_data
);

    logic [63:0]    rows_reg [4];
    logic           advance;
    logic           dot_valid;
    hvt_pkg::acc_t  acc [4];
    logic signed [hvt_pkg::CoordW-1:0] res [3];

    // The output register is the last stage; the pipeline moves when it
    // is empty or being taken, so a held output freezes everything behind.
    assign advance   = !out_valid || !out_stall;
    assign in_stall  = !advance;
    assign cfg_ready = 1'b1;

    // Row registers; an index beyond the last row is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg[0] <= hvt_pkg::Row0Reset;
            rows_reg[1] <= hvt_pkg::Row1Reset;
            rows_reg[2] <= hvt_pkg::Row2Reset;
            rows_reg[3] <= hvt_pkg::Row3Reset;
        end
        else if (cfg_valid && !cfg_index[hvt_pkg::CfgIdxW])
        begin
            case (cfg_index[hvt_pkg::CfgIdxW-1:0])
                hvt_pkg::RegRow0: rows_reg[0] <= cfg_data;
                hvt_pkg::RegRow1: rows_reg[1] <= cfg_data;
                hvt_pkg::RegRow2: rows_reg[2] <= cfg_data;
                hvt_pkg::RegRow3: rows_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    hvt_dot u_dot
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (in_valid),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .coord_z   (coord_z),
        .rows      (rows_reg),
        .out_valid (dot_valid),
        .acc       (acc)
    );

    hvt_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (dot_valid),
        .acc       (acc),
        .out_valid (out_valid),
        .res       (res),
        .w_zero    (w_zero),
        .saturated (saturated)
    );

    assign out_x = res[0];
    assign out_y = res[1];
    assign out_z = res[2];

    // A zero w never reports saturation.
    a_wz_nosat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && w_zero |-> !saturated)
        else $error("saturated set with zero w");
    // Zero w forces zero coordinates.
    a_wz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && w_zero |-> out_x == 0 && out_y == 0 && out_z == 0)
        else $error("nonzero output with zero w");
    // A stalled output holds its result.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(w_zero))
        else $error("output changed under stall");

endmodule
